// ===== sv/sbmq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants for the shared-buffer multi-queue: slot pointers,
// status codes, sequencer states and the slot memory write request.
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int NUM_QUEUES = 4;
    localparam int DATA_WIDTH = 32;
    localparam int QUEUE_W    = 2;
    localparam int PORT_W     = 32;

    // Slot address, and slot pointer with one extra bit for the null value
    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int SLOT_W = ADDR_W + 1;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [DATA_WIDTH-1:0] t_data;

    localparam t_slot NIL_SLOT = t_slot'(NUM_SLOTS);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_DONE
    } t_state;

    // One write into the slot memory: link and data may be written together
    typedef struct packed {
        logic  link_en;
        logic  data_en;
        t_addr addr;
        t_slot link;
        t_data data;
    } t_mem_wr;

    // Any pointer outside the slot range counts as null
    function automatic logic slot_ok(input t_slot s);
        return s < NIL_SLOT;
    endfunction

endpackage

// ===== sv/shared_buffer_multi_queue_top.sv =====
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// NUM_QUEUES FIFO queues sharing one linked slot buffer with a free list.
// ----------------------------------------------------------------------------
// Each input item is an enqueue or dequeue for one queue and yields exactly one
// result item (read data and status). Items are worked one at a time through
// the slot memory, whose read is registered: a dequeue reads the head slot, then
// unlinks it; an enqueue reads the free-list head, then writes the new slot, and
// into a non-empty queue a link step follows (it writes the old tail's link
// through the single write port). An item that fails at once (buffer full,
// queue empty, bad queue index) finishes without reading the memory. The result
// sits in an output register, so the next item is accepted while it waits; if
// that register is still held when a new result is ready, the sequencer holds
// the result until it frees. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_top
    import sbmq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_mode,
    input  logic [QUEUE_W-1:0]       i_queue_index,
    input  logic signed [PORT_W-1:0] i_write_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [PORT_W-1:0] o_read_data,
    output logic [1:0]               o_status
);

    t_state  r_state, n_state;
    logic    r_mode, n_mode;
    logic [QUEUE_W-1:0] r_q, n_q;
    t_data   r_wdata, n_wdata;
    t_slot   r_idx, n_idx;
    t_slot   r_prev_tail, n_prev_tail;
    t_slot   r_free_head, n_free_head;
    t_slot   r_qhead [NUM_QUEUES];
    t_slot   n_qhead [NUM_QUEUES];
    t_slot   r_qtail [NUM_QUEUES];
    t_slot   n_qtail [NUM_QUEUES];
    logic    r_out_valid, n_out_valid;
    t_data   r_out_data, n_out_data;
    t_status r_out_status, n_out_status;
    t_data   r_res_data, n_res_data;
    t_status r_res_status, n_res_status;

    logic    rd_en;
    t_addr   rd_addr;
    t_mem_wr wr;
    t_slot   rd_link;
    t_data   rd_data;

    logic    fin;
    t_data   fin_data;
    t_status fin_status;
    logic    out_free;
    logic    q_ok;
    t_slot   ptr;

    sbmq_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_link (rd_link),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer: issue read, write back, link old tail, deliver result
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_q          = r_q;
        n_wdata      = r_wdata;
        n_idx        = r_idx;
        n_prev_tail  = r_prev_tail;
        n_free_head  = r_free_head;
        n_qhead      = r_qhead;
        n_qtail      = r_qtail;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr           = '0;
        fin          = 1'b0;
        fin_data     = '0;
        fin_status   = ST_OK;
        q_ok         = ({1'b0, i_queue_index} < (QUEUE_W + 1)'(NUM_QUEUES));
        ptr          = NIL_SLOT;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (q_ok) begin
                        ptr = (i_mode == MODE_ENQ) ? r_free_head : r_qhead[i_queue_index];
                    end
                    n_mode  = i_mode;
                    n_q     = i_queue_index;
                    n_wdata = t_data'(i_write_data);
                    n_idx   = ptr;
                    if (!q_ok || !slot_ok(ptr)) begin
                        // Fail at once: nothing changes
                        fin        = 1'b1;
                        fin_status = (i_mode == MODE_ENQ) ? ST_FULL : ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ptr[ADDR_W-1:0];
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (r_mode == MODE_ENQ) begin
                    // Pop free list, terminate new slot, store data
                    n_free_head = slot_ok(rd_link) ? rd_link : NIL_SLOT;
                    wr.link_en  = 1'b1;
                    wr.data_en  = 1'b1;
                    wr.addr     = r_idx[ADDR_W-1:0];
                    wr.link     = NIL_SLOT;
                    wr.data     = r_wdata;
                    n_qtail[r_q] = r_idx;
                    n_prev_tail  = r_qtail[r_q];
                    if (!slot_ok(r_qhead[r_q]) || !slot_ok(r_qtail[r_q])) begin
                        n_qhead[r_q] = r_idx;
                        fin          = 1'b1;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    // Unlink head, push slot onto free list
                    if (slot_ok(rd_link)) begin
                        n_qhead[r_q] = rd_link;
                    end else begin
                        n_qhead[r_q] = NIL_SLOT;
                        n_qtail[r_q] = NIL_SLOT;
                    end
                    wr.link_en  = 1'b1;
                    wr.addr     = r_idx[ADDR_W-1:0];
                    wr.link     = r_free_head;
                    n_free_head = r_idx;
                    fin         = 1'b1;
                    fin_data    = rd_data;
                end
            end
            S_LINK: begin
                // Link old tail to the new slot
                wr.link_en = 1'b1;
                wr.addr    = r_prev_tail[ADDR_W-1:0];
                wr.link    = r_idx;
                fin        = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand a finished result to the output register or hold it
        if (fin) begin
            n_res_data   = fin_data;
            n_res_status = fin_status;
            n_state      = out_free ? S_IDLE : S_DONE;
        end
    end

    // Output register
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        if (fin && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = fin_data;
            n_out_status = fin_status;
        end else if ((r_state == S_DONE) && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_res_data;
            n_out_status = r_res_status;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_qhead[i] <= NIL_SLOT;
                r_qtail[i] <= NIL_SLOT;
            end
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_out_valid <= n_out_valid;
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_q          <= n_q;
        r_wdata      <= n_wdata;
        r_idx        <= n_idx;
        r_prev_tail  <= n_prev_tail;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = PORT_W'(r_out_data);
    assign o_status    = r_out_status;

    // Old-tail link step only follows an enqueue write-back
    a_link_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(r_state) == S_EXEC && r_mode == MODE_ENQ))
        else $error("link step out of sequence");

    // A dequeue puts its slot at the free-list head
    a_deq_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_mode == MODE_DEQ) |=> (r_free_head == $past(r_idx)))
        else $error("dequeued slot not freed");

    // Head and tail of a queue are null together
    for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_qchk
        a_head_tail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            slot_ok(r_qhead[g]) == slot_ok(r_qtail[g]))
            else $error("queue head and tail disagree on empty");
    end

endmodule

// ===== sv/sbmq_slot_mem.sv =====
// ----------------------------------------------------------------------------
// sbmq_slot_mem
// Slot storage: link and data memories with one write and one read port,
// read data registered. A link entry never written reads as its reset value,
// the next slot number, which makes the last slot link to null.
// ----------------------------------------------------------------------------
module sbmq_slot_mem
    import sbmq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rd_en,
    input  t_addr   i_rd_addr,
    input  t_mem_wr i_wr,
    output t_slot   o_rd_link,
    output t_data   o_rd_data
);

    t_slot mem_link [NUM_SLOTS];
    t_data mem_data [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] r_link_vld;
    t_slot                r_rd_link;
    t_data                r_rd_data;
    logic                 r_rd_vld;
    t_addr                r_rd_addr;

    // Write link and data
    always_ff @(posedge i_clk) begin
        if (i_wr.link_en) begin
            mem_link[i_wr.addr] <= i_wr.link;
        end
        if (i_wr.data_en) begin
            mem_data[i_wr.addr] <= i_wr.data;
        end
    end

    // Mark written link entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (i_wr.link_en) begin
            r_link_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_link <= mem_link[i_rd_addr];
            r_rd_data <= mem_data[i_rd_addr];
            r_rd_vld  <= r_link_vld[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Substitute the reset link for entries not yet written
    assign o_rd_link = r_rd_vld ? r_rd_link : (t_slot'(r_rd_addr) + t_slot'(1));
    assign o_rd_data = r_rd_data;

    // No read of an entry while it is being written
    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && (i_wr.link_en || i_wr.data_en) && (i_wr.addr == i_rd_addr)))
        else $error("slot read and write collide");

    // A data write always comes with a link write
    a_data_with_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.data_en |-> i_wr.link_en)
        else $error("data written without link");

    // A written entry stays marked
    a_vld_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_wr.link_en) && $past(i_rst_n) |-> r_link_vld[$past(i_wr.addr)])
        else $error("written link entry not marked");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared-buffer multi-queue. A queue of pending
// enqueue/dequeue items feeds a falling-edge driver; a rising-edge monitor
// predicts each accepted item against its own model of the linked slot buffer
// and free list, and checks every result item in order. The run steps through
// several sender-idle / receiver-stall phases.
// ----------------------------------------------------------------------------
module tb_top
    import sbmq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                     mode;
        logic [QUEUE_W-1:0]       qidx;
        logic signed [PORT_W-1:0] wdata;
    } t_op_item;

    typedef struct {
        logic signed [PORT_W-1:0] rdata;
        t_status                  status;
    } t_queue_result;

    localparam int MAX_REPORTS = 10;
    localparam int NUM_PHASES  = 4;
    localparam int RAND_ITEMS  = 385;

    // DUT ports
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_stall;
    logic                     i_mode        = MODE_ENQ;
    logic [QUEUE_W-1:0]       i_queue_index = '0;
    logic signed [PORT_W-1:0] i_write_data  = '0;
    logic                     o_out_valid;
    logic                     i_out_stall   = 1'b0;
    logic signed [PORT_W-1:0] o_read_data;
    logic [1:0]               o_status;

    // Bench state
    t_op_item      pending_ops[$];
    t_queue_result expected_results[$];
    t_op_item      drive_op;
    bit            in_taken      = 1'b0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            n_errors      = 0;
    int            n_accepted    = 0;
    int            n_enq_stored  = 0;
    int            n_deq_data    = 0;
    int            n_full        = 0;
    int            n_empty       = 0;

    // Predicted buffer contents
    t_data slot_mem[NUM_SLOTS];
    t_slot slot_next[NUM_SLOTS];
    t_slot free_ptr;
    t_slot q_first[NUM_QUEUES];
    t_slot q_last[NUM_QUEUES];

    shared_buffer_multi_queue_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_queue_index (i_queue_index),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_status      (o_status)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_live(input t_slot s);
        return s < t_slot'(NUM_SLOTS);
    endfunction

    // Initialize the free list to chain every slot in order
    task automatic clear_buffer_model();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_mem[i]  = '0;
            slot_next[i] = (i == NUM_SLOTS - 1) ? NIL_SLOT : t_slot'(i + 1);
        end
        free_ptr = '0;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            q_first[i] = NIL_SLOT;
            q_last[i]  = NIL_SLOT;
        end
    endtask

    // Apply one enqueue or dequeue to the buffer model and return its result
    task automatic predict_queue_op(input t_op_item op, output t_queue_result res);
        t_slot slot;
        int    q;
        q         = int'(op.qidx);
        res.rdata = '0;
        if (q >= NUM_QUEUES) begin
            res.status = (op.mode == MODE_DEQ) ? ST_EMPTY : ST_FULL;
        end else if (op.mode == MODE_ENQ) begin
            slot = free_ptr;
            if (!is_live(slot)) begin
                res.status = ST_FULL;
            end else begin
                free_ptr = slot_next[slot];
                if (!is_live(free_ptr))
                    free_ptr = NIL_SLOT;
                // link after the tail, or start the queue
                if (!is_live(q_first[q]) || !is_live(q_last[q]))
                    q_first[q] = slot;
                else
                    slot_next[q_last[q]] = slot;
                slot_next[slot] = NIL_SLOT;
                q_last[q]       = slot;
                slot_mem[slot]  = op.wdata;
                res.status      = ST_OK;
            end
        end else begin
            slot = q_first[q];
            if (!is_live(slot)) begin
                res.status = ST_EMPTY;
            end else begin
                q_first[q] = slot_next[slot];
                // last element gone: clear the tail too
                if (!is_live(q_first[q])) begin
                    q_first[q] = NIL_SLOT;
                    q_last[q]  = NIL_SLOT;
                end
                slot_next[slot] = free_ptr;
                free_ptr        = slot;
                res.rdata       = slot_mem[slot];
                res.status      = ST_OK;
            end
        end
        case (res.status)
            ST_OK:    if (op.mode == MODE_ENQ) n_enq_stored++; else n_deq_data++;
            ST_FULL:  n_full++;
            default:  n_empty++;
        endcase
    endtask

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic push_op(input logic mode, input int q, input logic [PORT_W-1:0] data);
        t_op_item op;
        op.mode  = mode;
        op.qidx  = QUEUE_W'(q);
        op.wdata = data;
        pending_ops = {pending_ops, op};
    endtask

    function automatic logic [PORT_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bursts with an enqueue, dequeue or even bias so occupancy swings full to empty
    task automatic add_random_traffic(input int n_items);
        int   made;
        int   burst_len;
        int   bias;
        int   focus_q;
        int   q;
        logic m;
        made = 0;
        while (made < n_items) begin
            burst_len = $urandom_range(80, 10);
            bias      = $urandom_range(2);
            focus_q   = $urandom_range(NUM_QUEUES - 1);
            for (int k = 0; k < burst_len && made < n_items; k++) begin
                case (bias)
                    0:       m = ($urandom_range(99) < 85) ? MODE_ENQ : MODE_DEQ;
                    1:       m = ($urandom_range(99) < 85) ? MODE_DEQ : MODE_ENQ;
                    default: m = 1'($urandom_range(1));
                endcase
                q = ($urandom_range(99) < 60) ? focus_q : $urandom_range(NUM_QUEUES - 1);
                push_op(m, q, rand_word());
                made++;
            end
        end
    endtask

    // Fill the whole buffer past full, then dequeue round-robin over all queues, more items than the buffer holds
    task automatic add_fill_and_drain();
        for (int k = 0; k < NUM_SLOTS + 6; k++)
            push_op(MODE_ENQ, $urandom_range(NUM_QUEUES - 1), rand_word());
        for (int k = 0; k < NUM_SLOTS + 10; k++)
            push_op(MODE_DEQ, k % NUM_QUEUES, rand_word());
    endtask

    task automatic add_directed();
        push_op(MODE_DEQ, 0, 32'h1234_5678);   // dequeue from an empty queue
        push_op(MODE_ENQ, 0, 32'h8000_0000);
        push_op(MODE_ENQ, 1, 32'h7FFF_FFFF);
        push_op(MODE_ENQ, 2, 32'h0000_0000);
        push_op(MODE_ENQ, 3, 32'hFFFF_FFFF);
        push_op(MODE_ENQ, 1, 32'h5555_5555);   // enqueue behind an existing tail
        push_op(MODE_ENQ, 1, 32'hAAAA_AAAA);
        push_op(MODE_DEQ, 1, 32'hFFFF_FFFF);
        push_op(MODE_DEQ, 1, 32'h0000_0000);
        push_op(MODE_DEQ, 1, 32'hAAAA_AAAA);   // removes the last element
        push_op(MODE_DEQ, 1, 32'h5555_5555);
        push_op(MODE_ENQ, 1, 32'h0F0F_F0F0);   // reuse after emptying
        push_op(MODE_DEQ, 0, 32'h0000_0000);
        push_op(MODE_DEQ, 0, 32'h0000_0000);
        push_op(MODE_ENQ, 0, 32'h1234_5678);
        push_op(MODE_DEQ, 2, 32'h0000_0000);
        push_op(MODE_DEQ, 3, 32'h0000_0000);
        push_op(MODE_DEQ, 1, 32'h0000_0000);
        push_op(MODE_DEQ, 0, 32'h0000_0000);
        push_op(MODE_DEQ, 3, 32'h0000_0000);
    endtask

    // Hold until every item is accepted and its result has come back
    task automatic wait_until_drained();
        while (pending_ops.size() != 0 || i_in_valid)
            @(posedge i_clk);
        for (int k = 0; k < 4000 && expected_results.size() != 0; k++)
            @(posedge i_clk);
    endtask

    // Driver: present the next item once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_op = pending_ops.pop_front();
                i_in_valid    <= 1'b1;
                i_mode        <= drive_op.mode;
                i_queue_index <= drive_op.qidx;
                i_write_data  <= drive_op.wdata;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: check result items first, then predict newly accepted items
    always @(posedge i_clk) begin
        t_op_item      seen_op;
        t_queue_result want;
        t_queue_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result with none pending: read_data=%0d status=%0d",
                                     o_read_data, o_status));
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.rdata || o_status !== want.status)
                    flag_error($sformatf(
                        "mismatch: read_data exp %0d got %0d, status exp %0d got %0d",
                        want.rdata, o_read_data, want.status, o_status));
            end
        end
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            seen_op.mode  = i_mode;
            seen_op.qidx  = i_queue_index;
            seen_op.wdata = i_write_data;
            predict_queue_op(seen_op, got);
            expected_results = {expected_results, got};
            n_accepted++;
        end
    end

    // Main sequence
    initial begin
        int idle_by_phase[NUM_PHASES];
        int stall_by_phase[NUM_PHASES];
        idle_by_phase  = '{0, 60, 0, 14};
        stall_by_phase = '{0, 0, 60, 14};
        clear_buffer_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = idle_by_phase[p];
            stall_pct     = stall_by_phase[p];
            if (p == 0) begin
                add_directed();
                add_fill_and_drain();
            end
            add_random_traffic(RAND_ITEMS);
            wait_until_drained();
        end

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("Summary: %0d items over %0d idle/stall phases, %0d mismatches",
                 n_accepted, NUM_PHASES, n_errors);
        $display("Summary: %0d enqueued, %0d dequeued with data, %0d full, %0d empty",
                 n_enq_stored, n_deq_data, n_full, n_empty);
        if (n_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
